// File: sv/hub75_threshold_row_scanner_assert.svh
// ---------------------------------------------------------------------------
// hub75 threshold row scanner assertion macros
// shared property forms for the scanner checks
// ---------------------------------------------------------------------------
`ifndef HUB75_THRESHOLD_ROW_SCANNER_ASSERT_SVH
`define HUB75_THRESHOLD_ROW_SCANNER_ASSERT_SVH

// antecedent implies consequent in the same cycle
`define HTS_ASSERT_SAME(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
		else $error(msg);

// antecedent implies consequent in the next cycle
`define HTS_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: sv/hts_pkg.sv
// ---------------------------------------------------------------------------
// hts_pkg
// item types, operation codes and colour field helpers for the scanner
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package hts_pkg;

	localparam logic OP_WRITE = 1'b0;
	localparam logic OP_SCAN  = 1'b1;

	localparam int RED_LSB   = 5;
	localparam int GREEN_LSB = 2;
	localparam logic [2:0] FIELD3_MASK = 3'h7;
	localparam logic [1:0] FIELD2_MASK = 2'h3;
	localparam logic [4:0] ROW_SEL_MASK = 5'h0F;

	typedef struct packed {
		logic       operation;
		logic [4:0] row;
		logic [5:0] column;
		logic [7:0] color;
		logic [2:0] threshold;
	} in_item_t;

	typedef struct packed {
		logic       upper_red;
		logic       upper_green;
		logic       upper_blue;
		logic       lower_red;
		logic       lower_green;
		logic       lower_blue;
		logic [3:0] row_select;
		logic [5:0] column_index;
		logic       last_column;
	} out_item_t;

	// travels alongside the registered read data
	typedef struct packed {
		logic       valid;
		logic       upper_ok;
		logic       lower_ok;
		logic [3:0] row_select;
		logic [5:0] column;
		logic       last;
		logic [2:0] threshold;
	} scan_tag_t;

	// red, green, blue above threshold
	function automatic logic [2:0] colour_bits(input logic [7:0] pix, input logic [2:0] thr);
		logic [2:0] red;
		logic [2:0] green;
		logic [2:0] blue;
		red   = pix[RED_LSB +: 3] & FIELD3_MASK;
		green = pix[GREEN_LSB +: 3] & FIELD3_MASK;
		blue  = {1'b0, pix[1:0] & FIELD2_MASK};
		return {red > thr, green > thr, blue > thr};
	endfunction

endpackage

// File: sv/hts_frame_mem.sv
// ---------------------------------------------------------------------------
// hts_frame_mem
// pixel store, one write port and two registered read ports
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_frame_mem #(
	parameter int ADDR_W = 11
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [7:0]        wdata,
	input  logic [ADDR_W-1:0] raddr_a,
	input  logic [ADDR_W-1:0] raddr_b,
	output logic [7:0]        rdata_a,
	output logic [7:0]        rdata_b
);

	localparam int DEPTH = 2 ** ADDR_W;

	logic [7:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_a <= mem[raddr_a];
		rdata_b <= mem[raddr_b];
	end

endmodule

// File: sv/hts_seq.sv
// ---------------------------------------------------------------------------
// hts_seq
// command sequencer: clearing pass, pixel writes and column sweep of a scan
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_seq #(
	parameter int PANEL_WIDTH  = 64,
	parameter int PANEL_HEIGHT = 32,
	parameter int ADDR_W       = 11
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	input  hts_pkg::in_item_t   cmd,
	output logic                busy,
	output logic                mem_we,
	output logic [ADDR_W-1:0]   mem_waddr,
	output logic [7:0]          mem_wdata,
	output logic [ADDR_W-1:0]   mem_raddr_a,
	output logic [ADDR_W-1:0]   mem_raddr_b,
	output hts_pkg::scan_tag_t  tag
);

	localparam int CW = $clog2(PANEL_WIDTH);
	localparam int RW = ADDR_W - CW;
	localparam logic [6:0] HEIGHT_L = 7'(PANEL_HEIGHT);
	localparam logic [6:0] WIDTH_L  = 7'(PANEL_WIDTH);
	localparam logic [6:0] HALF_L   = 7'(PANEL_HEIGHT / 2);
	localparam logic [CW-1:0] LAST_COL = CW'(PANEL_WIDTH - 1);

	typedef enum logic [2:0] {
		ST_CLEAR = 3'b001,
		ST_IDLE  = 3'b010,
		ST_SCAN  = 3'b100
	} state_t;

	state_t              st_q;
	logic [ADDR_W-1:0]   clr_q;
	logic [CW-1:0]       col_q;
	logic [RW-1:0]       urow_q;
	logic [RW-1:0]       lrow_q;
	logic                uok_q;
	logic                lok_q;
	logic [3:0]          rsel_q;
	logic [2:0]          thr_q;
	hts_pkg::scan_tag_t  tag_s1;

	logic       accept;
	logic [6:0] urow;
	logic [6:0] lrow;
	logic       wr_ok;

	assign accept = start && (st_q == ST_IDLE);
	assign busy   = (st_q != ST_IDLE);
	assign urow   = {2'b00, cmd.row};
	assign lrow   = urow + HALF_L;
	assign wr_ok  = accept && (cmd.operation == hts_pkg::OP_WRITE) &&
		(urow < HEIGHT_L) && ({1'b0, cmd.column} < WIDTH_L);

	always_comb begin
		if (st_q == ST_CLEAR) begin
			mem_we    = 1'b1;
			mem_waddr = clr_q;
			mem_wdata = 8'h00;
		end else begin
			mem_we    = wr_ok;
			mem_waddr = {urow[RW-1:0], cmd.column[CW-1:0]};
			mem_wdata = cmd.color;
		end
	end

	assign mem_raddr_a = {urow_q, col_q};
	assign mem_raddr_b = {lrow_q, col_q};
	assign tag         = tag_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q   <= ST_CLEAR;
			clr_q  <= '0;
			col_q  <= '0;
			tag_s1 <= '0;
		end else begin
			unique case (st_q)
				ST_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == '1) begin
						st_q <= ST_IDLE;
					end
				end
				ST_IDLE: begin
					if (accept && (cmd.operation == hts_pkg::OP_SCAN)) begin
						st_q  <= ST_SCAN;
						col_q <= '0;
					end
				end
				ST_SCAN: begin
					col_q <= col_q + 1'b1;
					if (col_q == LAST_COL) begin
						st_q <= ST_IDLE;
					end
				end
				default: st_q <= ST_IDLE;
			endcase
			tag_s1.valid      <= (st_q == ST_SCAN);
			tag_s1.upper_ok   <= uok_q;
			tag_s1.lower_ok   <= lok_q;
			tag_s1.row_select <= rsel_q;
			tag_s1.column     <= 6'(col_q);
			tag_s1.last       <= (col_q == LAST_COL);
			tag_s1.threshold  <= thr_q;
		end
	end

	// scan operands, held for the whole sweep
	always_ff @(posedge clk) begin
		if (accept && (cmd.operation == hts_pkg::OP_SCAN)) begin
			urow_q <= urow[RW-1:0];
			lrow_q <= lrow[RW-1:0];
			uok_q  <= (urow < HEIGHT_L);
			lok_q  <= (lrow < HEIGHT_L);
			rsel_q <= 4'(cmd.row & hts_pkg::ROW_SEL_MASK);
			thr_q  <= cmd.threshold;
		end
	end

endmodule

// File: sv/hub75_threshold_row_scanner.sv
// ---------------------------------------------------------------------------
// hub75_threshold_row_scanner
// rgb332 frame store with threshold compare, scanned out one row pair at a time
// ---------------------------------------------------------------------------
// command channel: item is taken at a rising edge with start high and busy low
//   operation write: stores one pixel, no result, busy stays low
//   operation scan: busy rises while the column counter sweeps the row pair
//   through both read ports of the frame store
// result channel: valid marks each result, PANEL_WIDTH results back to back
//   with no gap, column 0 first, last_column on the final one
// pipeline: each column address goes through the registered read, then the
//   registered compare, before its result is on the ports
// throughput: a new scan is taken only after the column counter ends its sweep;
//   one write per cycle while busy is low
// reset: the frame store is zeroed by a clearing pass over all
//   2**($clog2(PANEL_HEIGHT) + $clog2(PANEL_WIDTH)) addresses, 2048 at the
//   default size, during which busy is high
// the receiver cannot stall: each result is taken in the cycle it is shown
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "hub75_threshold_row_scanner_assert.svh"

module hub75_threshold_row_scanner #(
	parameter int PANEL_WIDTH  = 64,
	parameter int PANEL_HEIGHT = 32
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  hts_pkg::in_item_t  item,
	output logic               busy,
	output logic               valid,
	output hts_pkg::out_item_t result
);

	localparam int CW     = $clog2(PANEL_WIDTH);
	localparam int RW     = $clog2(PANEL_HEIGHT);
	localparam int ADDR_W = RW + CW;

	logic                mem_we;
	logic [ADDR_W-1:0]   mem_waddr;
	logic [7:0]          mem_wdata;
	logic [ADDR_W-1:0]   mem_raddr_a;
	logic [ADDR_W-1:0]   mem_raddr_b;
	logic [7:0]          rdata_a;
	logic [7:0]          rdata_b;
	hts_pkg::scan_tag_t  tag;

	logic                valid_q;
	hts_pkg::out_item_t  result_q;
	logic [7:0]          upix;
	logic [7:0]          lpix;
	logic [2:0]          ubits;
	logic [2:0]          lbits;

	hts_seq #(
		.PANEL_WIDTH  (PANEL_WIDTH),
		.PANEL_HEIGHT (PANEL_HEIGHT),
		.ADDR_W       (ADDR_W)
	) u_seq (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.cmd         (item),
		.busy        (busy),
		.mem_we      (mem_we),
		.mem_waddr   (mem_waddr),
		.mem_wdata   (mem_wdata),
		.mem_raddr_a (mem_raddr_a),
		.mem_raddr_b (mem_raddr_b),
		.tag         (tag)
	);

	hts_frame_mem #(
		.ADDR_W (ADDR_W)
	) u_mem (
		.clk     (clk),
		.we      (mem_we),
		.waddr   (mem_waddr),
		.wdata   (mem_wdata),
		.raddr_a (mem_raddr_a),
		.raddr_b (mem_raddr_b),
		.rdata_a (rdata_a),
		.rdata_b (rdata_b)
	);

	// rows beyond the panel read dark
	assign upix  = tag.upper_ok ? rdata_a : 8'h00;
	assign lpix  = tag.lower_ok ? rdata_b : 8'h00;
	assign ubits = hts_pkg::colour_bits(upix, tag.threshold);
	assign lbits = hts_pkg::colour_bits(lpix, tag.threshold);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= tag.valid;
		end
	end

	always_ff @(posedge clk) begin
		result_q.upper_red    <= ubits[2];
		result_q.upper_green  <= ubits[1];
		result_q.upper_blue   <= ubits[0];
		result_q.lower_red    <= lbits[2];
		result_q.lower_green  <= lbits[1];
		result_q.lower_blue   <= lbits[0];
		result_q.row_select   <= tag.row_select;
		result_q.column_index <= tag.column;
		result_q.last_column  <= tag.last;
	end

	assign valid  = valid_q;
	assign result = result_q;

	`HTS_ASSERT_NEXT(a_scan_sets_busy, clk, arst_n, start && !busy && (item.operation == hts_pkg::OP_SCAN), busy, "scan transaction did not raise busy")
	`HTS_ASSERT_NEXT(a_results_contiguous, clk, arst_n, valid && !result.last_column, valid, "gap inside a scan burst")
	`HTS_ASSERT_NEXT(a_gap_after_last, clk, arst_n, valid && result.last_column, !valid, "result directly after the last column")
	`HTS_ASSERT_SAME(a_first_column_zero, clk, arst_n, valid && !$past(valid), result.column_index == 6'd0, "burst does not open on column zero")

endmodule

// File: tb/sv/hts_scan_checker.sv
// ---------------------------------------------------------------------------
// hts_scan_checker
// mirrors the rgb332 frame store from the command channel, predicts the
// column transactions of every row pair scan and compares them, field by
// field and in order, against the result channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module hts_scan_checker (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	input  logic               busy,
	input  hts_pkg::in_item_t  item,
	input  logic               valid,
	input  hts_pkg::out_item_t result,
	output int                 fail_count,
	output int                 columns_due
);

	localparam int WIDTH  = 64;
	localparam int HEIGHT = 32;

	logic [7:0]         pixel_mem [0:HEIGHT-1][0:WIDTH-1];
	hts_pkg::out_item_t expected_columns [$];

	task automatic clear_store();
		for (int r = 0; r < HEIGHT; r++) begin
			for (int c = 0; c < WIDTH; c++) begin
				pixel_mem[r][c] = 8'h00;
			end
		end
		expected_columns.delete();
	endtask

	// red, green, blue strictly above the threshold; rows past the panel are dark
	function automatic logic [2:0] lit_fields(input logic [5:0] r, input logic [5:0] c,
			input logic [2:0] thr);
		logic [7:0] pix;
		pix = (r < HEIGHT) ? pixel_mem[r[4:0]][c] : 8'h00;
		return {pix[7:5] > thr, pix[4:2] > thr, {1'b0, pix[1:0]} > thr};
	endfunction

	function automatic hts_pkg::out_item_t column_view(input logic [4:0] r, input int c,
			input logic [2:0] thr);
		hts_pkg::out_item_t o;
		logic [5:0]         col;
		col = c[5:0];
		{o.upper_red, o.upper_green, o.upper_blue} = lit_fields({1'b0, r}, col, thr);
		{o.lower_red, o.lower_green, o.lower_blue} = lit_fields({1'b0, r} + 6'd16, col, thr);
		o.row_select   = r[3:0];
		o.column_index = col;
		o.last_column  = (c == WIDTH - 1);
		return o;
	endfunction

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			fail_count++;
		end
	endtask

	initial begin
		fail_count  = 0;
		columns_due = 0;
		clear_store();
	end

	always @(posedge clk or negedge arst_n) begin : watch
		hts_pkg::out_item_t want;
		if (!arst_n) begin
			clear_store();
		end else begin
			if (valid) begin
				if (expected_columns.size() == 0) begin
					$error("column transaction with nothing expected: %h", result);
					fail_count++;
				end else begin
					want = expected_columns.pop_front();
					check_field("upper_red", want.upper_red, result.upper_red);
					check_field("upper_green", want.upper_green, result.upper_green);
					check_field("upper_blue", want.upper_blue, result.upper_blue);
					check_field("lower_red", want.lower_red, result.lower_red);
					check_field("lower_green", want.lower_green, result.lower_green);
					check_field("lower_blue", want.lower_blue, result.lower_blue);
					check_field("row_select", want.row_select, result.row_select);
					check_field("column_index", want.column_index, result.column_index);
					check_field("last_column", want.last_column, result.last_column);
				end
			end
			if (start && !busy) begin
				if (item.operation == hts_pkg::OP_WRITE) begin
					pixel_mem[item.row][item.column] = item.color;
				end else begin
					for (int c = 0; c < WIDTH; c++) begin
						expected_columns.push_back(column_view(item.row, c, item.threshold));
					end
				end
			end
		end
		columns_due = expected_columns.size();
	end

endmodule

// File: tb/sv/tb_top.sv
// ---------------------------------------------------------------------------
// tb_top
// drives pixel writes and row pair scans into the scanner through phases of
// sender idling, and leaves prediction and comparison to the checker
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_top;

	localparam int QUIET_LIMIT = 20000;
	localparam int PHASE_ITEMS = 55;

	logic               clk;
	logic               arst_n;
	logic               start;
	hts_pkg::in_item_t  item;
	logic               busy;
	logic               valid;
	hts_pkg::out_item_t result;
	logic               took;
	int                 quiet;
	int                 fail_count;
	int                 columns_due;

	hub75_threshold_row_scanner dut (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.item   (item),
		.busy   (busy),
		.valid  (valid),
		.result (result)
	);

	hts_scan_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.item        (item),
		.valid       (valid),
		.result      (result),
		.fail_count  (fail_count),
		.columns_due (columns_due)
	);

	initial clk = 1'b0;
	always #10 clk = ~clk;

	// transaction seen at each edge, and a watchdog on stretches with none
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			took  <= 1'b0;
			quiet <= 0;
		end else begin
			took <= start && !busy;
			if ((start && !busy) || valid) begin
				quiet <= 0;
			end else if (quiet >= QUIET_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				quiet <= quiet + 1;
			end
		end
	end

	function automatic hts_pkg::in_item_t pack_item(input logic op, input logic [4:0] r,
			input logic [5:0] c, input logic [7:0] colour, input logic [2:0] thr);
		hts_pkg::in_item_t it;
		it.operation = op;
		it.row       = r;
		it.column    = c;
		it.color     = colour;
		it.threshold = thr;
		return it;
	endfunction

	task automatic pause(input int idle_pct);
		while ($urandom_range(99) < idle_pct) begin
			start <= 1'b0;
			@(negedge clk);
		end
	endtask

	task automatic issue(input hts_pkg::in_item_t it);
		item  <= it;
		start <= 1'b1;
		do @(negedge clk); while (!took);
	endtask

	task automatic pixel(input logic [4:0] r, input logic [5:0] c, input logic [7:0] colour);
		issue(pack_item(hts_pkg::OP_WRITE, r, c, colour, 3'($urandom_range(7))));
	endtask

	task automatic scan(input logic [4:0] r, input logic [2:0] thr);
		issue(pack_item(hts_pkg::OP_SCAN, r, 6'($urandom_range(63)),
			8'($urandom_range(255)), thr));
	endtask

	int          idle_pct [4] = '{0, 85, 17, 0};
	logic [3:0]  hot_pair;
	logic [4:0]  r;

	initial begin
		arst_n = 1'b0;
		start  = 1'b0;
		item   = '0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// corners, both halves, single fields, then scans at thresholds from 0 up to 7
		pixel(5'd0, 6'd0, 8'hFF);
		pixel(5'd31, 6'd63, 8'hFF);
		pixel(5'd16, 6'd0, 8'hE0);
		pixel(5'd15, 6'd63, 8'hB6);
		pixel(5'd16, 6'd63, 8'h49);
		pixel(5'd0, 6'd1, 8'h1C);
		pixel(5'd0, 6'd2, 8'h03);
		pixel(5'd0, 6'd3, 8'h01);
		pixel(5'd0, 6'd4, 8'h02);
		pixel(5'd0, 6'd32, 8'h24);
		pixel(5'd16, 6'd32, 8'h6D);
		scan(5'd0, 3'd0);
		scan(5'd0, 3'd7);
		scan(5'd0, 3'd2);
		scan(5'd0, 3'd1);
		scan(5'd15, 3'd3);
		scan(5'd16, 3'd0);
		scan(5'd31, 3'd0);
		scan(5'd31, 3'd6);
		pixel(5'd0, 6'd0, 8'h00);
		scan(5'd0, 3'd0);
		scan(5'd15, 3'd0);

		foreach (idle_pct[p]) begin
			hot_pair = 4'($urandom_range(15));
			for (int n = 0; n < PHASE_ITEMS; n++) begin
				pause(idle_pct[p]);
				r = $urandom_range(99) < 70 ? {1'($urandom_range(1)), hot_pair}
					: 5'($urandom_range(31));
				if ($urandom_range(99) < 65)
					pixel(r, 6'($urandom_range(63)), 8'($urandom_range(255)));
				else
					scan(r, 3'($urandom_range(7)));
			end
		end
		start <= 1'b0;

		while (columns_due != 0) @(negedge clk);
		repeat (8) @(negedge clk);
		if (fail_count == 0 && columns_due == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

endmodule
